/* hw/rtl/mfd_pkg.sv */
// package for the frame deframer: phase type and frame constants
// no dependencies

package mfd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_e;

  localparam logic [7:0] MarkV1     = 8'hFE;
  localparam logic [7:0] MarkV2     = 8'hFD;
  localparam int         SignedBit  = 0;
  localparam logic [7:0] HdrLenV1   = 8'd6;
  localparam logic [7:0] HdrLenV2   = 8'd10;
  localparam logic [7:0] CrcLen     = 8'd2;
  localparam logic [7:0] SigLen     = 8'd13;

  // header byte positions, marker at 0
  localparam logic [7:0] PosLen     = 8'd1;
  localparam logic [7:0] PosFlags   = 8'd2;
  localparam logic [7:0] PosSysV1   = 8'd3;
  localparam logic [7:0] PosCompV1  = 8'd4;
  localparam logic [7:0] PosMsgV1   = 8'd5;
  localparam logic [7:0] PosSysV2   = 8'd5;
  localparam logic [7:0] PosCompV2  = 8'd6;
  localparam logic [7:0] PosMsg0V2  = 8'd7;
  localparam logic [7:0] PosMsg1V2  = 8'd8;
  localparam logic [7:0] PosMsg2V2  = 8'd9;

endpackage

/* hw/rtl/mavlink_frame_deframer.sv */
// frame deframer top level: byte stream in, payload bytes and frame ends out
// depends on mfd_pkg
//
//   side   | handshake                 | payload
//   in     | in_valid_i / in_stall_o   | rx_byte_i
//   out    | out_valid_o / out_stall_i | out_frame_end_o .. out_is_signed_o
//
// one byte per cycle while in_stall_o is low; the result appears in the cycle after its byte is taken
// the phase registers update in the cycle a byte is taken
// a single result register holds the result; input stalls only while it is
// full and stalled
// reset returns to hunting with all header fields cleared

module mavlink_frame_deframer
  import mfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_frame_end_o,
  output logic [7:0]  out_data_byte_o,
  output logic [7:0]  out_byte_index_o,
  output logic [23:0] out_message_id_o,
  output logic [7:0]  out_system_id_o,
  output logic [7:0]  out_component_id_o,
  output logic        out_is_v2_o,
  output logic [7:0]  out_payload_length_o,
  output logic        out_is_signed_o
);

  phase_e      phase_q, phase_d;
  logic        v2_q, v2_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic        sgn_q, sgn_d;
  logic [7:0]  sys_q, sys_d;
  logic [7:0]  comp_q, comp_d;
  logic [23:0] msg_q, msg_d;

  logic        in_acc;
  logic        res_vld;
  logic        res_end;
  logic [7:0]  pos_inc;
  logic [7:0]  hdr_len;
  logic [7:0]  trl_len;

  logic        out_vld_q;
  logic        end_q;
  logic [7:0]  data_q;
  logic [7:0]  idx_q;
  logic [23:0] omsg_q;
  logic [7:0]  osys_q;
  logic [7:0]  ocomp_q;
  logic        ov2_q;
  logic [7:0]  olen_q;
  logic        osgn_q;

  assign in_stall_o = out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_inc    = pos_q + 8'd1;
  assign hdr_len    = v2_q ? HdrLenV2 : HdrLenV1;
  assign trl_len    = sgn_q ? (CrcLen + SigLen) : CrcLen;

  always_comb begin
    phase_d = phase_q;
    v2_d    = v2_q;
    pos_d   = pos_q;
    len_d   = len_q;
    sgn_d   = sgn_q;
    sys_d   = sys_q;
    comp_d  = comp_q;
    msg_d   = msg_q;
    res_vld = 1'b0;
    res_end = 1'b0;
    unique case (phase_q)
      PH_HEADER: begin
        if (v2_q) begin
          if (pos_q == PosLen)         len_d       = rx_byte_i;
          else if (pos_q == PosFlags)  sgn_d       = rx_byte_i[SignedBit];
          else if (pos_q == PosSysV2)  sys_d       = rx_byte_i;
          else if (pos_q == PosCompV2) comp_d      = rx_byte_i;
          else if (pos_q == PosMsg0V2) msg_d[7:0]  = rx_byte_i;
          else if (pos_q == PosMsg1V2) msg_d[15:8] = rx_byte_i;
          else if (pos_q == PosMsg2V2) msg_d[23:16] = rx_byte_i;
        end else begin
          if (pos_q == PosLen)         len_d  = rx_byte_i;
          else if (pos_q == PosSysV1)  sys_d  = rx_byte_i;
          else if (pos_q == PosCompV1) comp_d = rx_byte_i;
          else if (pos_q == PosMsgV1)  msg_d  = {16'd0, rx_byte_i};
        end
        pos_d = pos_inc;
        if (pos_inc >= hdr_len) begin
          pos_d   = 8'd0;
          phase_d = (len_d != 8'd0) ? PH_PAYLOAD : PH_TRAILER;
        end
      end
      PH_PAYLOAD: begin
        res_vld = 1'b1;
        pos_d   = pos_inc;
        if (pos_inc >= len_q) begin
          pos_d   = 8'd0;
          phase_d = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        pos_d = pos_inc;
        if (pos_inc >= trl_len) begin
          pos_d   = 8'd0;
          phase_d = PH_HUNT;
          res_vld = 1'b1;
          res_end = 1'b1;
        end
      end
      PH_HUNT: begin
        if (rx_byte_i == MarkV1 || rx_byte_i == MarkV2) begin
          v2_d    = (rx_byte_i == MarkV2);
          len_d   = 8'd0;
          sgn_d   = 1'b0;
          sys_d   = 8'd0;
          comp_d  = 8'd0;
          msg_d   = 24'd0;
          pos_d   = 8'd1;
          phase_d = PH_HEADER;
        end else begin
          pos_d = 8'd0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      v2_q    <= 1'b0;
      pos_q   <= 8'd0;
      len_q   <= 8'd0;
      sgn_q   <= 1'b0;
      sys_q   <= 8'd0;
      comp_q  <= 8'd0;
      msg_q   <= 24'd0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      v2_q    <= v2_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      sgn_q   <= sgn_d;
      sys_q   <= sys_d;
      comp_q  <= comp_d;
      msg_q   <= msg_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_vld) begin
      end_q   <= res_end;
      data_q  <= res_end ? 8'd0 : rx_byte_i;
      idx_q   <= res_end ? 8'd0 : pos_q;
      omsg_q  <= msg_q;
      osys_q  <= sys_q;
      ocomp_q <= comp_q;
      ov2_q   <= v2_q;
      olen_q  <= len_q;
      osgn_q  <= sgn_q;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign out_frame_end_o      = end_q;
  assign out_data_byte_o      = data_q;
  assign out_byte_index_o     = idx_q;
  assign out_message_id_o     = omsg_q;
  assign out_system_id_o      = osys_q;
  assign out_component_id_o   = ocomp_q;
  assign out_is_v2_o          = ov2_q;
  assign out_payload_length_o = olen_q;
  assign out_is_signed_o      = osgn_q;

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> len_q != 8'd0)
    else $error("payload phase with zero length");

  a_marker_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q == PH_HUNT && (rx_byte_i == MarkV1 || rx_byte_i == MarkV2)
    |=> phase_q == PH_HEADER && pos_q == 8'd1)
    else $error("marker did not start header");

  a_end_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_end |=> phase_q == PH_HUNT && out_vld_q)
    else $error("frame end without return to hunting");

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && end_q |-> data_q == 8'd0 && idx_q == 8'd0)
    else $error("frame end carries data");

  a_signed_v2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && osgn_q |-> ov2_q)
    else $error("signed flag on v1 frame");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for mavlink_frame_deframer: directed byte table, then random frames
// predicts results in-line unless a table row sets them; depends on mfd_pkg and deframer rtl

module testbench;
  import mfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 312;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        frame_end;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [23:0] message_id;
    logic [7:0]  system_id;
    logic [7:0]  component_id;
    logic        is_v2;
    logic [7:0]  payload_length;
    logic        is_signed;
  } deframe_result_t;

  typedef enum logic [1:0] {
    EXP_PREDICTED,
    EXP_NOTHING,
    EXP_TYPED
  } exp_kind_e;

  typedef struct packed {
    logic [7:0]      rx;
    exp_kind_e       kind;
    deframe_result_t want;
  } stim_row_t;

  localparam deframe_result_t V1_EMPTY_END = '{frame_end: 1'b1, data_byte: 8'h00,
    byte_index: 8'h00, message_id: 24'h0000FF, system_id: 8'hFF, component_id: 8'h00,
    is_v2: 1'b0, payload_length: 8'h00, is_signed: 1'b0};
  localparam deframe_result_t V2_SHORT_END = '{frame_end: 1'b1, data_byte: 8'h00,
    byte_index: 8'h00, message_id: 24'h112233, system_id: 8'h01, component_id: 8'h02,
    is_v2: 1'b1, payload_length: 8'h02, is_signed: 1'b0};

  localparam stim_row_t DIRECTED [24] = '{
    // hunting drops non-markers
    '{8'h00, EXP_NOTHING, '0},
    // v1, empty payload, extreme header values
    '{MarkV1, EXP_NOTHING, '0},
    '{8'h00, EXP_NOTHING, '0},
    '{8'h7A, EXP_NOTHING, '0},
    '{8'hFF, EXP_NOTHING, '0},
    '{8'h00, EXP_NOTHING, '0},
    '{8'hFF, EXP_NOTHING, '0},
    '{8'h11, EXP_NOTHING, '0},
    '{8'h22, EXP_TYPED, V1_EMPTY_END},
    // v2, fields cleared by new marker, markers inside payload
    '{MarkV2, EXP_NOTHING, '0},
    '{8'h02, EXP_NOTHING, '0},
    '{8'hFE, EXP_NOTHING, '0},
    '{8'hFF, EXP_NOTHING, '0},
    '{8'h00, EXP_NOTHING, '0},
    '{8'h01, EXP_NOTHING, '0},
    '{8'h02, EXP_NOTHING, '0},
    '{8'h33, EXP_NOTHING, '0},
    '{8'h22, EXP_NOTHING, '0},
    '{8'h11, EXP_NOTHING, '0},
    '{MarkV1, EXP_PREDICTED, '0},
    '{MarkV2, EXP_PREDICTED, '0},
    '{8'hAB, EXP_NOTHING, '0},
    '{8'hCD, EXP_TYPED, V2_SHORT_END},
    '{8'hFC, EXP_NOTHING, '0}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_frame_end_o;
  logic [7:0]  out_data_byte_o;
  logic [7:0]  out_byte_index_o;
  logic [23:0] out_message_id_o;
  logic [7:0]  out_system_id_o;
  logic [7:0]  out_component_id_o;
  logic        out_is_v2_o;
  logic [7:0]  out_payload_length_o;
  logic        out_is_signed_o;

  mavlink_frame_deframer DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .out_frame_end_o,
    .out_data_byte_o,
    .out_byte_index_o,
    .out_message_id_o,
    .out_system_id_o,
    .out_component_id_o,
    .out_is_v2_o,
    .out_payload_length_o,
    .out_is_signed_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // deframer shadow state
  phase_e      dfr_phase = PH_HUNT;
  logic        frame_v2 = 1'b0;
  logic [8:0]  dfr_pos = '0;
  logic [7:0]  frame_len = '0;
  logic        frame_signed = 1'b0;
  logic [7:0]  frame_sys = '0;
  logic [7:0]  frame_comp = '0;
  logic [23:0] frame_msgid = '0;

  deframe_result_t expected_q[$];
  int              mismatches = 0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  exp_kind_e       row_kind = EXP_PREDICTED;
  deframe_result_t row_want = '0;

  function automatic deframe_result_t tag_result(logic fe, logic [7:0] data, logic [7:0] idx);
    return '{frame_end: fe, data_byte: data, byte_index: idx, message_id: frame_msgid,
             system_id: frame_sys, component_id: frame_comp, is_v2: frame_v2,
             payload_length: frame_len, is_signed: frame_signed};
  endfunction

  function automatic void deframe_step(input logic [7:0] rx, output bit emits,
                                       output deframe_result_t res);
    emits = 1'b0;
    res = '0;
    case (dfr_phase)
      PH_HEADER: begin
        if (frame_v2) begin
          case (dfr_pos)
            PosLen:    frame_len = rx;
            PosFlags:  frame_signed = rx[SignedBit];
            PosSysV2:  frame_sys = rx;
            PosCompV2: frame_comp = rx;
            PosMsg0V2: frame_msgid = frame_msgid | {16'h0, rx};
            PosMsg1V2: frame_msgid = frame_msgid | {8'h0, rx, 8'h0};
            PosMsg2V2: frame_msgid = frame_msgid | {rx, 16'h0};
            default: ;
          endcase
        end else begin
          case (dfr_pos)
            PosLen:    frame_len = rx;
            PosSysV1:  frame_sys = rx;
            PosCompV1: frame_comp = rx;
            PosMsgV1:  frame_msgid = {16'h0, rx};
            default: ;
          endcase
        end
        dfr_pos = dfr_pos + 9'd1;
        if (dfr_pos >= (frame_v2 ? HdrLenV2 : HdrLenV1)) begin
          dfr_pos = '0;
          dfr_phase = (frame_len != 0) ? PH_PAYLOAD : PH_TRAILER;
        end
      end
      PH_PAYLOAD: begin
        emits = 1'b1;
        res = tag_result(1'b0, rx, dfr_pos[7:0]);
        dfr_pos = dfr_pos + 9'd1;
        if (dfr_pos >= frame_len) begin
          dfr_pos = '0;
          dfr_phase = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        dfr_pos = dfr_pos + 9'd1;
        if (dfr_pos >= CrcLen + (frame_signed ? SigLen : 8'd0)) begin
          dfr_pos = '0;
          dfr_phase = PH_HUNT;
          emits = 1'b1;
          res = tag_result(1'b1, 8'h00, 8'h00);
        end
      end
      default: begin
        if (rx == MarkV1 || rx == MarkV2) begin
          frame_v2 = (rx == MarkV2);
          frame_len = '0;
          frame_signed = 1'b0;
          frame_sys = '0;
          frame_comp = '0;
          frame_msgid = '0;
          dfr_pos = 9'd1;
          dfr_phase = PH_HEADER;
        end else begin
          dfr_pos = '0;
          dfr_phase = PH_HUNT;
        end
      end
    endcase
  endfunction

  function automatic string show(deframe_result_t r);
    return {$sformatf("end=%0d data=%02h idx=%0d msg=%06h ",
                      r.frame_end, r.data_byte, r.byte_index, r.message_id),
            $sformatf("sys=%02h comp=%02h v2=%0d len=%0d sig=%0d",
                      r.system_id, r.component_id, r.is_v2, r.payload_length,
                      r.is_signed)};
  endfunction

  // prediction on input transfers, checking on output transfers
  bit              mon_emits;
  deframe_result_t mon_res;
  deframe_result_t mon_got;
  deframe_result_t mon_want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        deframe_step(rx_byte_i, mon_emits, mon_res);
        if (row_kind == EXP_NOTHING) begin
          mon_emits = 1'b0;
        end else if (row_kind == EXP_TYPED) begin
          mon_emits = 1'b1;
          mon_res = row_want;
        end
        if (mon_emits) expected_q.push_back(mon_res);
      end
      if (out_valid_o && !out_stall_i) begin
        mon_got = '{out_frame_end_o, out_data_byte_o, out_byte_index_o, out_message_id_o,
                    out_system_id_o, out_component_id_o, out_is_v2_o,
                    out_payload_length_o, out_is_signed_o};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) $display("unexpected result: %s", show(mon_got));
        end else begin
          mon_want = expected_q.pop_front();
          if (mon_got !== mon_want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", show(mon_want));
              $display("  actual   %s", show(mon_got));
            end
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] rx, input exp_kind_e kind,
                           input deframe_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= rx;
    row_kind <= kind;
    row_want <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_pause();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] payload_pick();
    case ($urandom_range(7))
      0: return MarkV1;
      1: return MarkV2;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input int len, input bit truncate, output int sent);
    logic [7:0] frame_q[$];
    bit         v2;
    bit         sgn;
    int         cut;
    v2 = 1'($urandom_range(1));
    sgn = v2 && ($urandom_range(2) == 0);
    frame_q.push_back(v2 ? MarkV2 : MarkV1);
    frame_q.push_back(len[7:0]);
    if (v2) begin
      frame_q.push_back({7'($urandom_range(127)), sgn});
      repeat (7) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat (4) frame_q.push_back(8'($urandom_range(255)));
    end
    repeat (len) frame_q.push_back(payload_pick());
    repeat (CrcLen + (sgn ? SigLen : 8'd0)) frame_q.push_back(8'($urandom_range(255)));
    cut = truncate ? int'($urandom_range(frame_q.size() - 1, 1)) : frame_q.size();
    for (int i = 0; i < cut; i++) send_byte(frame_q[i], EXP_PREDICTED, '0);
    sent = cut;
  endtask

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    int sent;
    int n;
    int pick;
    int len;
    idle_by_phase = '{0, 60, 0, 33};
    stall_by_phase = '{0, 0, 60, 33};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].kind, DIRECTED[i].want);
    drain_pause();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      sent = 0;
      if (ph == 0) begin
        send_frame(255, 1'b0, n);
        sent += n;
      end
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          len = $urandom_range(99);
          if (len < 10) len = 0;
          else if (len < 90) len = $urandom_range(12, 1);
          else len = $urandom_range(64, 13);
          send_frame(len, pick >= 70, n);
          sent += n;
        end else begin
          n = $urandom_range(4, 1);
          repeat (n) send_byte(8'($urandom_range(8'hFC)), EXP_PREDICTED, '0);
          sent += n;
        end
      end
      drain_pause();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("mavlink_frame_deframer regression: pass");
    end else begin
      $display("mavlink_frame_deframer regression: fail");
    end
    $finish;
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("mavlink_frame_deframer regression: fail");
    $finish;
  end

endmodule

/* mavlink_frame_deframer.f */
hw/rtl/mfd_pkg.sv
hw/rtl/mavlink_frame_deframer.sv
tb/sv/testbench.sv
